[hw/rtl/clcf_pkg.sv]
// shared types, codes and constants of the character lcd cursor front end
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package clcf_pkg;

	// default geometry of the display
	localparam int COLUMNS_DEF    = 40;
	localparam int LINE2_BASE_DEF = 64;

	// request opcodes
	localparam logic [2:0] OP_PRINT = 3'd0;
	localparam logic [2:0] OP_MOVE  = 3'd1;
	localparam logic [2:0] OP_CLEAR = 3'd2;
	localparam logic [2:0] OP_HOME  = 3'd3;
	localparam logic [2:0] OP_INIT  = 3'd4;

	// screen selector codes
	localparam logic [1:0] SCR_UPPER   = 2'd0;
	localparam logic [1:0] SCR_LOWER   = 2'd1;
	localparam logic [1:0] SCR_BOTH    = 2'd2;
	localparam logic [1:0] SCR_INVALID = 2'd3;

	// special characters
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_RETURN  = 8'h0D;

	// lcd commands
	localparam logic [7:0] CMD_SET_ADDR      = 8'h80;
	localparam logic [7:0] CMD_CLEAR_DISPLAY = 8'h01;
	localparam logic [7:0] CMD_RETURN_HOME   = 8'h02;

	// number of commands in the init sequence
	localparam logic [2:0] INIT_LEN = 3'd6;

	// request item
	typedef struct packed {
		logic [2:0] opcode;
		logic [1:0] screen_select;
		logic [7:0] char_or_position;
	} req_item_t;

	// result item
	typedef struct packed {
		logic [7:0] bus_byte;
		logic       is_data;
		logic       strobe_upper;
		logic       strobe_lower;
		logic       last;
	} rsp_item_t;

	// decoded plan of one request, handed to the emitter
	typedef struct packed {
		logic [2:0] count;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic       data0;
		logic       init;
		logic       strobe_upper;
		logic       strobe_lower;
	} plan_t;

	// init sequence: function set, clear, display on, entry mode, shift, home
	function automatic logic [7:0] init_byte(input logic [2:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0:    b = 8'h38;
			3'd1:    b = 8'h01;
			3'd2:    b = 8'h0C;
			3'd3:    b = 8'h06;
			3'd4:    b = 8'h14;
			3'd5:    b = 8'h02;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

[hw/rtl/clcf_cursor.sv]
// cursor registers of both controllers and the request decoder
// depends on clcf_pkg
`timescale 1ns / 1ps

module clcf_cursor import clcf_pkg::*; #(
	parameter int COLUMNS    = COLUMNS_DEF,
	parameter int LINE2_BASE = LINE2_BASE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_item_t item,
	input  logic      apply,
	output plan_t     plan
);

	localparam logic [7:0] COLS8 = 8'(COLUMNS);
	localparam logic [7:0] TWO8  = 8'(2 * COLUMNS);
	localparam logic [6:0] COLS7 = 7'(COLUMNS);
	localparam logic [7:0] BASE8 = 8'(LINE2_BASE);

	logic [6:0] upper_q;
	logic [6:0] lower_q;
	logic [6:0] cur;
	logic [6:0] cur_next;
	logic [6:0] upd_val;
	logic       upd_en;
	logic       sel_upper;
	logic       sel_lower;

	// set-address command for a cursor position
	function automatic logic [7:0] set_addr(input logic [6:0] pos);
		logic [7:0] a;
		if ({1'b0, pos} >= COLS8) begin
			a = BASE8 + ({1'b0, pos} - COLS8);
		end else begin
			a = {1'b0, pos};
		end
		return CMD_SET_ADDR | a;
	endfunction

	assign sel_upper = (item.screen_select == SCR_UPPER) || (item.screen_select == SCR_BOTH);
	assign sel_lower = (item.screen_select == SCR_LOWER) || (item.screen_select == SCR_BOTH);
	assign cur       = (item.screen_select == SCR_LOWER) ? lower_q : upper_q;
	assign cur_next  = cur + 7'd1;

	// decode one request into results and a cursor update
	always_comb begin
		plan              = '0;
		plan.strobe_upper = sel_upper;
		plan.strobe_lower = sel_lower;
		upd_val           = '0;
		upd_en            = 1'b0;
		if (item.screen_select != SCR_INVALID) begin
			unique case (item.opcode)
				OP_PRINT: begin
					if (item.screen_select != SCR_BOTH) begin
						if (item.char_or_position == CH_NEWLINE) begin
							// jump to the start of the other line
							if ({1'b0, cur} < COLS8) begin
								plan.count = 3'd1;
								plan.byte0 = set_addr(COLS7);
								upd_val    = COLS7;
								upd_en     = 1'b1;
							end else if ({1'b0, cur} < TWO8) begin
								plan.count = 3'd1;
								plan.byte0 = set_addr(7'd0);
								upd_en     = 1'b1;
							end
						end else if (item.char_or_position == CH_RETURN) begin
							// back to the start of the current line
							if ({1'b0, cur} < COLS8) begin
								plan.count = 3'd1;
								plan.byte0 = set_addr(7'd0);
								upd_en     = 1'b1;
							end else if ({1'b0, cur} < TWO8) begin
								plan.count = 3'd1;
								plan.byte0 = set_addr(COLS7);
								upd_val    = COLS7;
								upd_en     = 1'b1;
							end
						end else begin
							// character data, wrap to the first cell past the end
							plan.count = 3'd1;
							plan.byte0 = item.char_or_position;
							plan.data0 = 1'b1;
							upd_en     = 1'b1;
							if ({1'b0, cur_next} >= TWO8) begin
								plan.count = 3'd2;
								plan.byte1 = set_addr(7'd0);
							end else begin
								upd_val = cur_next;
							end
						end
					end
				end
				OP_MOVE: begin
					if (item.char_or_position < TWO8) begin
						plan.count = 3'd1;
						plan.byte0 = set_addr(item.char_or_position[6:0]);
						upd_val    = item.char_or_position[6:0];
						upd_en     = 1'b1;
					end
				end
				OP_CLEAR: begin
					plan.count = 3'd1;
					plan.byte0 = CMD_CLEAR_DISPLAY;
					upd_en     = 1'b1;
				end
				OP_HOME: begin
					plan.count = 3'd1;
					plan.byte0 = CMD_RETURN_HOME;
					upd_en     = 1'b1;
				end
				OP_INIT: begin
					plan.count = INIT_LEN;
					plan.init  = 1'b1;
					upd_en     = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// cursor update when the request is handed on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= '0;
			lower_q <= '0;
		end else if (apply && upd_en) begin
			if (sel_upper) begin
				upper_q <= upd_val;
			end
			if (sel_lower) begin
				lower_q <= upd_val;
			end
		end
	end

endmodule

[hw/rtl/clcf_emit.sv]
// result emitter: holds one decoded request and sends its results in order
// depends on clcf_pkg
`timescale 1ns / 1ps

module clcf_emit import clcf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  plan_t     plan,
	input  logic      load,
	output logic      free,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	logic       busy_q;
	logic [2:0] idx_q;
	plan_t      plan_q;
	logic       take;
	logic       is_last;

	assign is_last   = (idx_q == (plan_q.count - 3'd1));
	assign take      = busy_q && !rsp_stall;
	assign free      = !busy_q || (take && is_last);
	assign rsp_valid = busy_q;

	// current result from the held plan
	always_comb begin
		rsp.bus_byte     = plan_q.init ? init_byte(idx_q)
		                 : ((idx_q == 3'd0) ? plan_q.byte0 : plan_q.byte1);
		rsp.is_data      = (idx_q == 3'd0) && plan_q.data0;
		rsp.strobe_upper = plan_q.strobe_upper;
		rsp.strobe_lower = plan_q.strobe_lower;
		rsp.last         = is_last;
	end

	// busy flag and result index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (take && is_last) begin
			busy_q <= 1'b0;
		end else if (take) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	// held plan
	always_ff @(posedge clk) begin
		if (load) begin
			plan_q <= plan;
		end
	end

endmodule

[hw/rtl/char_lcd_cursor_front_end.sv]
// Front end for a dual-controller two-line character LCD.
// Request channel (req_valid, req_stall, req): opcode, screen select and a
// character or cursor position. Result channel (rsp_valid, rsp_stall, rsp):
// one bus byte per item, marked command or data, with a strobe per
// controller; last marks the final result of a request.
// A request is registered in the input register at acceptance, decoded against
// the cursors from there, and moves into the emitter once it is free; its
// first result shows from the emitter register.
// Results leave at one per cycle while the receiver does not stall; a request
// holds the emitter until its last result (one to six) is taken, and a
// request that makes no result leaves the input register without loading the
// emitter. The input register takes a new request in the cycle in which the
// previous one moves on, so requests follow back to back while results drain.
// Reset clears both cursors to position 0 and empties both registers.
// When the receiver stalls, the shown result holds, the emitter waits and
// a waiting request with results raises req_stall until the emitter frees.
// Depends on clcf_pkg, clcf_cursor and clcf_emit.
`timescale 1ns / 1ps

module char_lcd_cursor_front_end import clcf_pkg::*; #(
	parameter int COLUMNS    = COLUMNS_DEF,
	parameter int LINE2_BASE = LINE2_BASE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	logic      valid_s1;
	req_item_t item_s1;
	plan_t     plan;
	logic      free;
	logic      load;
	logic      move_s1;

	// input register hands on when the emitter is free or nothing is emitted
	assign load      = valid_s1 && (plan.count != 3'd0) && free;
	assign move_s1   = valid_s1 && ((plan.count == 3'd0) || free);
	assign req_stall = valid_s1 && !move_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= req;
		end
	end

	// cursor state and decode
	clcf_cursor #(
		.COLUMNS    (COLUMNS),
		.LINE2_BASE (LINE2_BASE)
	) u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.apply  (load),
		.plan   (plan)
	);

	// result sequencing
	clcf_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.plan      (plan),
		.load      (load),
		.free      (free),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

[hw/rtl/clcf_checker.sv]
// port-level checks of the character lcd cursor front end, bound to the top
// depends on clcf_pkg and char_lcd_cursor_front_end
`timescale 1ns / 1ps

module clcf_checker import clcf_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_stall,
	input req_item_t req,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input rsp_item_t rsp
);

	// a stalled request holds
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("stalled request changed");

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	// every result strobes at least one controller
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.strobe_upper || rsp.strobe_lower))
		else $error("result without strobe");

	// character data goes to exactly one controller
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_data |-> $onehot({rsp.strobe_upper, rsp.strobe_lower}))
		else $error("data result to both or no controller");

	// a request does not stop before its last result
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_stall && !rsp.last |=> rsp_valid)
		else $error("result sequence broken before last");

endmodule

bind char_lcd_cursor_front_end clcf_checker u_clcf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

[test/tb_char_lcd_cursor_front_end.sv]
// testbench for char_lcd_cursor_front_end: directed and random requests with
// stalls on both channels, results checked against a cursor-tracking scoreboard
// depends on clcf_pkg and the char_lcd_cursor_front_end rtl
`timescale 1ns / 1ps

module tb_char_lcd_cursor_front_end;
	import clcf_pkg::*;

	// opcodes that the block must ignore
	localparam logic [2:0] OP_RSVD_5 = 3'd5;
	localparam logic [2:0] OP_RSVD_6 = 3'd6;
	localparam logic [2:0] OP_RSVD_7 = 3'd7;

	localparam int          CELLS        = 2 * COLUMNS_DEF;
	localparam int          RANDOM_ITEMS = 155;
	localparam int          CALM_ITEMS   = 40;
	localparam int          HOLD_CYCLES  = 60;
	localparam int          DRAIN_CYCLES = 12;
	localparam int unsigned CYCLE_LIMIT  = 200000;

	// tracks both cursors and holds the bus bytes still owed by the block
	class lcd_cursor_scoreboard;
		rsp_item_t   owed_q[$];
		rsp_item_t   batch_q[$];
		logic [6:0]  upper_pos;
		logic [6:0]  lower_pos;
		int unsigned mismatches;

		function new();
			upper_pos  = '0;
			lower_pos  = '0;
			mismatches = 0;
		endfunction

		function void add_byte(logic [7:0] b, logic data, logic [1:0] scr);
			rsp_item_t x;
			x.bus_byte     = b;
			x.is_data      = data;
			x.strobe_upper = (scr == SCR_UPPER || scr == SCR_BOTH);
			x.strobe_lower = (scr == SCR_LOWER || scr == SCR_BOTH);
			x.last         = 1'b0;
			batch_q.push_back(x);
		endfunction

		function void place(logic [1:0] scr, int pos);
			if (scr == SCR_UPPER || scr == SCR_BOTH) begin
				upper_pos = pos[6:0];
			end
			if (scr == SCR_LOWER || scr == SCR_BOTH) begin
				lower_pos = pos[6:0];
			end
		endfunction

		// set-address command; second line starts at its own ddram base
		function void jump_to(logic [1:0] scr, int pos);
			int addr;
			addr = (pos >= COLUMNS_DEF) ? LINE2_BASE_DEF + pos - COLUMNS_DEF : pos;
			place(scr, pos);
			add_byte(CMD_SET_ADDR | 8'(addr), 1'b0, scr);
		endfunction

		// work out the bus bytes of one accepted request
		function void note_request(req_item_t r);
			logic [7:0] power_up [6];
			logic [1:0] scr;
			int         cur;
			power_up = '{8'h38, 8'h01, 8'h0C, 8'h06, 8'h14, 8'h02};
			scr = r.screen_select;
			batch_q.delete();
			if (scr != SCR_INVALID) begin
				case (r.opcode)
					OP_PRINT: begin
						if (scr != SCR_BOTH) begin
							cur = (scr == SCR_UPPER) ? upper_pos : lower_pos;
							if (r.char_or_position == CH_NEWLINE) begin
								if (cur < COLUMNS_DEF) jump_to(scr, COLUMNS_DEF);
								else if (cur < CELLS) jump_to(scr, 0);
							end else if (r.char_or_position == CH_RETURN) begin
								if (cur < COLUMNS_DEF) jump_to(scr, 0);
								else if (cur < CELLS) jump_to(scr, COLUMNS_DEF);
							end else begin
								add_byte(r.char_or_position, 1'b1, scr);
								cur = (cur + 1) & 'h7F;
								place(scr, cur);
								if (cur > CELLS - 1) jump_to(scr, 0);
							end
						end
					end
					OP_MOVE: begin
						if (r.char_or_position < CELLS) jump_to(scr, r.char_or_position);
					end
					OP_CLEAR: begin
						place(scr, 0);
						add_byte(CMD_CLEAR_DISPLAY, 1'b0, scr);
					end
					OP_HOME: begin
						place(scr, 0);
						add_byte(CMD_RETURN_HOME, 1'b0, scr);
					end
					OP_INIT: begin
						place(scr, 0);
						for (int i = 0; i < int'(INIT_LEN); i++) add_byte(power_up[i], 1'b0, scr);
					end
					default: ;
				endcase
			end
			if (batch_q.size() > 0) batch_q[batch_q.size() - 1].last = 1'b1;
			foreach (batch_q[i]) owed_q.push_back(batch_q[i]);
		endfunction

		function void report(string what, rsp_item_t want, rsp_item_t got);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t %s: expected byte=%h data=%b up=%b lo=%b last=%b", $time, what,
					want.bus_byte, want.is_data, want.strobe_upper, want.strobe_lower, want.last);
				$display("%0t %s:      got byte=%h data=%b up=%b lo=%b last=%b", $time, what,
					got.bus_byte, got.is_data, got.strobe_upper, got.strobe_lower, got.last);
			end
		endfunction

		// compare one accepted result with the oldest owed byte
		function void check_result(rsp_item_t got);
			rsp_item_t want;
			if (owed_q.size() == 0) begin
				report("unexpected result", '0, got);
			end else begin
				want = owed_q.pop_front();
				if (got.bus_byte !== want.bus_byte || got.is_data !== want.is_data ||
					got.strobe_upper !== want.strobe_upper ||
					got.strobe_lower !== want.strobe_lower || got.last !== want.last) begin
					report("result mismatch", want, got);
				end
			end
		endfunction

		function int unsigned outstanding();
			return owed_q.size();
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_item_t rsp;

	lcd_cursor_scoreboard board;
	int unsigned          n_accepted = 0;
	int unsigned          cycle_count;
	bit                   calm = 1'b0;
	bit                   pressure_on = 1'b0;
	bit                   pressure_done = 1'b0;

	char_lcd_cursor_front_end u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watch both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				board.note_request(req);
				n_accepted++;
			end
			if (rsp_valid && !rsp_stall) board.check_result(rsp);
		end
	end

	// give up on a hung run
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	// result side: random stall bursts and one long hold-off to back up the block
	initial begin
		rsp_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (!pressure_done && n_accepted >= 40) begin
				pressure_on = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				pressure_on   = 1'b0;
				pressure_done = 1'b1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				rsp_stall <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	function automatic req_item_t request_of(logic [2:0] op, logic [1:0] scr, logic [7:0] arg);
		req_item_t r;
		r.opcode           = op;
		r.screen_select    = scr;
		r.char_or_position = arg;
		return r;
	endfunction

	// mostly prints and legal moves, with some edge positions and noise
	function automatic req_item_t random_request();
		req_item_t r;
		int        pick;
		int        scr_pick;
		pick     = $urandom_range(0, 99);
		scr_pick = $urandom_range(0, 99);
		if (scr_pick < 44) r.screen_select = SCR_UPPER;
		else if (scr_pick < 88) r.screen_select = SCR_LOWER;
		else if (scr_pick < 95) r.screen_select = SCR_BOTH;
		else r.screen_select = SCR_INVALID;
		r.char_or_position = 8'($urandom_range(0, 255));
		if (pick < 50) begin
			r.opcode = OP_PRINT;
			pick = $urandom_range(0, 9);
			if (pick == 0) r.char_or_position = CH_NEWLINE;
			else if (pick == 1) r.char_or_position = CH_RETURN;
		end else if (pick < 70) begin
			r.opcode = OP_MOVE;
			pick = $urandom_range(0, 5);
			if (pick < 2) r.char_or_position = 8'($urandom_range(CELLS - 8, CELLS - 1));
			else if (pick < 5) r.char_or_position = 8'($urandom_range(0, CELLS - 1));
		end else if (pick < 78) begin
			r.opcode = OP_CLEAR;
		end else if (pick < 86) begin
			r.opcode = OP_HOME;
		end else if (pick < 92) begin
			r.opcode = OP_INIT;
		end else begin
			r.opcode = 3'($urandom_range(OP_RSVD_5, OP_RSVD_7));
		end
		return r;
	endfunction

	// offer one item, with an optional idle burst first, and wait until taken
	task automatic offer(input req_item_t r);
		if (!calm && !pressure_on && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	initial begin
		board = new();
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// init sequences, plain prints at the byte extremes
		offer(request_of(OP_INIT, SCR_UPPER, 8'h00));
		offer(request_of(OP_INIT, SCR_LOWER, 8'hFF));
		offer(request_of(OP_INIT, SCR_BOTH, 8'h5A));
		offer(request_of(OP_PRINT, SCR_UPPER, 8'h41));
		offer(request_of(OP_PRINT, SCR_LOWER, 8'h00));
		offer(request_of(OP_PRINT, SCR_UPPER, 8'hFF));
		// printing to both screens or to no valid screen does nothing
		offer(request_of(OP_PRINT, SCR_BOTH, 8'h41));
		offer(request_of(OP_PRINT, SCR_INVALID, 8'h41));
		// wrap past the last cell
		offer(request_of(OP_MOVE, SCR_UPPER, 8'(CELLS - 1)));
		offer(request_of(OP_PRINT, SCR_UPPER, 8'h7E));
		// newline and carriage return on both lines
		offer(request_of(OP_MOVE, SCR_LOWER, 8'(COLUMNS_DEF - 1)));
		offer(request_of(OP_PRINT, SCR_LOWER, CH_NEWLINE));
		offer(request_of(OP_PRINT, SCR_LOWER, CH_RETURN));
		offer(request_of(OP_PRINT, SCR_LOWER, CH_NEWLINE));
		offer(request_of(OP_PRINT, SCR_LOWER, CH_RETURN));
		// out-of-range moves, then a legal move to the first cell, clear and home
		offer(request_of(OP_MOVE, SCR_BOTH, 8'(CELLS)));
		offer(request_of(OP_MOVE, SCR_BOTH, 8'hFF));
		offer(request_of(OP_MOVE, SCR_BOTH, 8'h00));
		offer(request_of(OP_CLEAR, SCR_BOTH, 8'h00));
		offer(request_of(OP_HOME, SCR_UPPER, 8'h00));
		// unused opcodes and an invalid screen
		offer(request_of(OP_RSVD_5, SCR_UPPER, 8'h00));
		offer(request_of(OP_RSVD_6, SCR_LOWER, 8'h00));
		offer(request_of(OP_RSVD_7, SCR_UPPER, 8'hFF));
		offer(request_of(OP_CLEAR, SCR_INVALID, 8'h00));
		offer(request_of(OP_MOVE, SCR_LOWER, 8'(COLUMNS_DEF)));

		// random requests, the last stretch without idling
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
			offer(random_request());
		end
		req_valid <= 1'b0;

		// drain
		while (board.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.outstanding() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

[files.f]
hw/rtl/clcf_pkg.sv
hw/rtl/clcf_cursor.sv
hw/rtl/clcf_emit.sv
hw/rtl/char_lcd_cursor_front_end.sv
hw/rtl/clcf_checker.sv
test/tb_char_lcd_cursor_front_end.sv
